>>> rtl/sct_pkg.sv
// Shared types, character codes and helpers for the s-expression character tokenizer.
// No dependencies; imported by every module of the block.
package sct_pkg;

  // character codes
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SEMICOLON = 8'h3B;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_VTAB      = 8'h0B;
  localparam logic [7:0] CH_FORMFEED  = 8'h0C;
  localparam logic [7:0] CH_RETURN    = 8'h0D;

  // most results that one input item can cause
  localparam int unsigned MAX_RESULTS = 3;
  // default depth of the result queue (power of two, at least four)
  localparam int unsigned RESULT_QUEUE_DEPTH = 8;

  // lexer mode, one-hot
  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'b001,
    MODE_STRING  = 3'b010,
    MODE_COMMENT = 3'b100
  } lex_mode_t;

  typedef struct packed {
    lex_mode_t mode;
    logic      token_open;
    logic      prev_backslash;
  } lex_state_t;

  localparam lex_state_t LEX_STATE_RESET = '{mode: MODE_NORMAL, token_open: 1'b0,
                                             prev_backslash: 1'b0};

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_token_end;
    logic       is_string_token;
    logic       last_of_run;
  } out_item_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE) ||
           (c == CH_VTAB) || (c == CH_FORMFEED) || (c == CH_RETURN);
  endfunction

  function automatic logic is_bracket(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACKET) || (c == CH_RBRACKET);
  endfunction

  // one result item, not yet marked as last of its run
  function automatic out_item_t make_item(input logic [7:0] ch, input logic is_end,
                                          input logic is_str);
    out_item_t r;
    r.out_char        = ch;
    r.is_token_end    = is_end;
    r.is_string_token = is_str;
    r.last_of_run     = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/sct_decode.sv
// Combinational lexer step: from the current lexer state and one input item, the
// next state and up to three result items. Depends on sct_pkg.
module sct_decode (
  input  sct_pkg::lex_state_t state,
  input  sct_pkg::in_item_t   item,
  output sct_pkg::lex_state_t state_next,
  output sct_pkg::out_item_t  results [sct_pkg::MAX_RESULTS],
  output logic [1:0]          result_count
);
  import sct_pkg::*;

  logic [7:0] c;
  logic [1:0] n;

  assign c = item.in_char;

  always_comb begin
    state_next = state;
    n = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      results[i] = '0;
    end

    unique case (state.mode)
      // inside a string: every byte is carried, an unescaped quote closes it
      MODE_STRING: begin
        results[n] = make_item(c, 1'b0, 1'b1);
        n = n + 2'd1;
        if ((c == CH_QUOTE) && !state.prev_backslash) begin
          results[n] = make_item(8'h00, 1'b1, 1'b1);
          n = n + 2'd1;
          state_next = LEX_STATE_RESET;
        end else begin
          state_next.prev_backslash = (c == CH_BACKSLASH);
        end
      end
      // comment bytes are dropped up to and including the newline
      MODE_COMMENT: begin
        if (c == CH_NEWLINE) begin
          state_next.mode = MODE_NORMAL;
        end
      end
      default: begin
        state_next.mode = MODE_NORMAL;
        if ((c == CH_SEMICOLON) || (c == CH_QUOTE) || is_space(c) || is_bracket(c)) begin
          // delimiter closes any open atom
          if (state.token_open) begin
            results[n] = make_item(8'h00, 1'b1, 1'b0);
            n = n + 2'd1;
          end
          state_next.token_open = 1'b0;
          if (c == CH_SEMICOLON) begin
            state_next.mode = MODE_COMMENT;
          end else if (c == CH_QUOTE) begin
            results[n] = make_item(c, 1'b0, 1'b1);
            n = n + 2'd1;
            state_next.mode           = MODE_STRING;
            state_next.token_open     = 1'b1;
            state_next.prev_backslash = 1'b0;
          end else if (is_bracket(c)) begin
            results[n] = make_item(c, 1'b0, 1'b0);
            n = n + 2'd1;
            results[n] = make_item(8'h00, 1'b1, 1'b0);
            n = n + 2'd1;
          end
        end else begin
          results[n] = make_item(c, 1'b0, 1'b0);
          n = n + 2'd1;
          state_next.token_open = 1'b1;
        end
      end
    endcase

    // end of text flushes the open token and returns to reset state
    if (item.end_of_text) begin
      if (state_next.token_open) begin
        results[n] = make_item(8'h00, 1'b1, state_next.mode == MODE_STRING);
        n = n + 2'd1;
      end
      state_next = LEX_STATE_RESET;
    end

    if (n != 2'd0) begin
      results[n - 2'd1].last_of_run = 1'b1;
    end
  end

  assign result_count = n;

endmodule

>>> rtl/sct_result_queue.sv
// Result queue: takes up to three result items per cycle, hands out one per cycle while dst_ready is high.
// Depends on sct_pkg.
module sct_result_queue #(
  parameter int unsigned DEPTH = sct_pkg::RESULT_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sct_pkg::out_item_t push_items [sct_pkg::MAX_RESULTS],
  input  logic [1:0]         push_count,
  output logic               room,
  output logic               dst_valid,
  input  logic               dst_ready,
  output sct_pkg::out_item_t dst_item
);
  import sct_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - MAX_RESULTS);

  out_item_t       entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [1:0]      push_n;
  logic            pop;

  assign push_n    = push ? push_count : 2'd0;
  assign pop       = dst_valid && dst_ready;
  assign dst_valid = (count != '0);
  assign dst_item  = entries[rd_ptr];
  // room for a worst-case item, independent of the drain side
  assign room      = (count <= ROOM_LIMIT);

  // entry storage: slot i takes the result at its offset from the write pointer
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      logic [AW-1:0] offset;
      offset = AW'(i) - wr_ptr;
      if (offset < AW'(push_n)) begin
        entries[i] <= push_items[offset[1:0]];
      end
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + CW'(push_n) - CW'(pop);
    end
  end

endmodule

>>> rtl/sexpr_char_tokenizer_core.sv
// Top level of the s-expression character tokenizer: lexer state registers,
// step logic and result queue. Depends on sct_pkg, sct_decode, sct_result_queue.
//
// One source byte is taken per clock cycle while src_ready is high. Each byte gives
// zero to three result items (a bracket after an atom gives three), which leave
// through a result queue of QUEUE_DEPTH entries at one item per cycle while dst_ready
// is high. src_ready depends only on the queue fill level: it is high while at least
// three entries are free, so with the output side taking every cycle the input is
// taken every cycle as long as the text averages no more than one result per byte;
// bracket bursts are absorbed by the queue. Results of a byte appear on dst in the
// cycle after it is taken at the earliest.
module sexpr_char_tokenizer_core #(
  parameter int unsigned QUEUE_DEPTH = sct_pkg::RESULT_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  sct_pkg::in_item_t src_item,
  output logic              dst_valid,
  input  logic              dst_ready,
  output sct_pkg::out_item_t dst_item
);
  import sct_pkg::*;

  lex_state_t state;
  lex_state_t state_next;
  out_item_t  results [MAX_RESULTS];
  logic [1:0] result_count;
  logic       accept;

  assign accept = src_valid && src_ready;

  // lexer step
  sct_decode u_decode (
    .state        (state),
    .item         (src_item),
    .state_next   (state_next),
    .results      (results),
    .result_count (result_count)
  );

  // lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LEX_STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // result buffering
  sct_result_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_items (results),
    .push_count (result_count),
    .room       (src_ready),
    .dst_valid  (dst_valid),
    .dst_ready  (dst_ready),
    .dst_item   (dst_item)
  );

  // a string is always an open token
  assert property (@(posedge clk) disable iff (rst)
    (state.mode == MODE_STRING) |-> state.token_open)
    else $error("string mode without open token");

  // escape flag only lives inside a string
  assert property (@(posedge clk) disable iff (rst)
    state.prev_backslash |-> (state.mode == MODE_STRING))
    else $error("escape flag set outside string");

  // nothing is open while a comment is skipped
  assert property (@(posedge clk) disable iff (rst)
    (state.mode == MODE_COMMENT) |-> !state.token_open)
    else $error("open token inside comment");

  // end of text returns the lexer to its reset state
  assert property (@(posedge clk) disable iff (rst)
    (accept && src_item.end_of_text) |=> (state == LEX_STATE_RESET))
    else $error("lexer state not cleared after end of text");

endmodule

>>> test/sct_checker.sv
// Checker for the s-expression character tokenizer: watches both item channels,
// predicts the token stream of every accepted source byte and compares the results.
// Depends on sct_pkg for the item types, lexer modes and character codes.
`timescale 1ns / 1ps

module sct_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  input  logic               src_ready,
  input  sct_pkg::in_item_t  src_item,
  input  logic               dst_valid,
  input  logic               dst_ready,
  input  sct_pkg::out_item_t dst_item,
  output int                 fail_count,
  output int                 pending
);
  import sct_pkg::*;

  // predicted lexer state
  lex_mode_t lex_mode;
  logic      in_token;
  logic      after_backslash;

  // token items predicted but not yet seen on the output
  out_item_t token_stream_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    lex_mode        = MODE_NORMAL;
    in_token        = 1'b0;
    after_backslash = 1'b0;
  end

  function automatic logic is_blank(input logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_NEWLINE, CH_VTAB, CH_FORMFEED, CH_RETURN: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_delim_bracket(input logic [7:0] c);
    case (c)
      CH_LPAREN, CH_RPAREN, CH_LBRACKET, CH_RBRACKET: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic out_item_t token_part(input logic [7:0] ch, input logic is_end,
                                           input logic is_str);
    out_item_t r;
    r.out_char        = ch;
    r.is_token_end    = is_end;
    r.is_string_token = is_str;
    r.last_of_run     = 1'b0;
    return r;
  endfunction

  // work out the token items caused by one source byte and queue them
  task automatic lex_byte(input in_item_t it);
    out_item_t run[$];
    logic [7:0] c;
    c = it.in_char;
    case (lex_mode)
      MODE_STRING: begin
        run = {run, token_part(c, 1'b0, 1'b1)};
        if (c == CH_QUOTE && !after_backslash) begin
          run = {run, token_part(8'h00, 1'b1, 1'b1)};
          lex_mode        = MODE_NORMAL;
          in_token        = 1'b0;
          after_backslash = 1'b0;
        end else begin
          after_backslash = (c == CH_BACKSLASH);
        end
      end
      MODE_COMMENT: begin
        // comment bytes are dropped up to and including the newline
        if (c == CH_NEWLINE) lex_mode = MODE_NORMAL;
      end
      default: begin
        if (c == CH_SEMICOLON || c == CH_QUOTE || is_blank(c) || is_delim_bracket(c)) begin
          if (in_token) run = {run, token_part(8'h00, 1'b1, 1'b0)};
          in_token = 1'b0;
          if (c == CH_SEMICOLON) begin
            lex_mode = MODE_COMMENT;
          end else if (c == CH_QUOTE) begin
            run = {run, token_part(c, 1'b0, 1'b1)};
            lex_mode        = MODE_STRING;
            in_token        = 1'b1;
            after_backslash = 1'b0;
          end else if (is_delim_bracket(c)) begin
            // a bracket is a token of its own
            run = {run, token_part(c, 1'b0, 1'b0)};
            run = {run, token_part(8'h00, 1'b1, 1'b0)};
          end
        end else begin
          run = {run, token_part(c, 1'b0, 1'b0)};
          in_token = 1'b1;
        end
      end
    endcase

    // end of text flushes any open token and restarts the lexer
    if (it.end_of_text) begin
      if (in_token) run = {run, token_part(8'h00, 1'b1, lex_mode == MODE_STRING)};
      lex_mode        = MODE_NORMAL;
      in_token        = 1'b0;
      after_backslash = 1'b0;
    end

    if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[i]) token_stream_q = {token_stream_q, run[i]};
  endtask

  // compare outgoing items first: they always belong to earlier source bytes
  always @(posedge clk) begin
    out_item_t want;
    logic      bad;
    if (rst) begin
      lex_mode        = MODE_NORMAL;
      in_token        = 1'b0;
      after_backslash = 1'b0;
      token_stream_q.delete();
    end else begin
      if (dst_valid && dst_ready) begin
        if (token_stream_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected item char=%h end=%b str=%b last=%b", $time,
                   dst_item.out_char, dst_item.is_token_end, dst_item.is_string_token,
                   dst_item.last_of_run);
        end else begin
          want = token_stream_q.pop_front();
          bad  = (dst_item.out_char !== want.out_char) ||
                 (dst_item.is_token_end !== want.is_token_end) ||
                 (dst_item.is_string_token !== want.is_string_token) ||
                 (dst_item.last_of_run !== want.last_of_run);
          if (bad) begin
            fail_count++;
            $display({"%0t: mismatch expected char=%h end=%b str=%b last=%b, ",
                      "got char=%h end=%b str=%b last=%b"},
                     $time, want.out_char, want.is_token_end, want.is_string_token,
                     want.last_of_run, dst_item.out_char, dst_item.is_token_end,
                     dst_item.is_string_token, dst_item.last_of_run);
          end
        end
      end
      if (src_valid && src_ready) lex_byte(src_item);
    end
    pending = token_stream_q.size();
  end

endmodule

>>> test/tb_top.sv
// Testbench top for the s-expression character tokenizer: clock, reset, source
// text stimulus and output stalls. Depends on sct_pkg, sexpr_char_tokenizer_core
// and sct_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb_top;
  import sct_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned HOLD_OFF     = 300;
  localparam int unsigned DRAIN_CYCLES = 30;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_ready;
  in_item_t  src_item  = '0;
  logic      dst_valid;
  logic      dst_ready = 1'b0;
  out_item_t dst_item;
  int        fail_count;
  int        pending;

  in_item_t  source_text[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sexpr_char_tokenizer_core dut (
    .clk      (clk),
    .rst      (rst),
    .src_valid(src_valid),
    .src_ready(src_ready),
    .src_item (src_item),
    .dst_valid(dst_valid),
    .dst_ready(dst_ready),
    .dst_item (dst_item)
  );

  sct_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_item  (dst_item),
    .fail_count(fail_count),
    .pending   (pending)
  );

  task automatic add_byte(input logic [7:0] c, input logic eot);
    in_item_t it;
    it.in_char     = c;
    it.end_of_text = eot;
    source_text = {source_text, it};
  endtask

  // end of text lands on roughly one byte in fifty
  task automatic add_text_byte(input logic [7:0] c);
    add_byte(c, $urandom_range(0, 49) == 0);
  endtask

  function automatic logic [7:0] atom_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom);
    end while (c == CH_QUOTE || c == CH_SEMICOLON || is_space(c) || is_bracket(c));
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_NEWLINE;
      3: return CH_VTAB;
      4: return CH_FORMFEED;
      default: return CH_RETURN;
    endcase
  endfunction

  function automatic logic [7:0] bracket_char();
    case ($urandom_range(0, 3))
      0: return CH_LPAREN;
      1: return CH_RPAREN;
      2: return CH_LBRACKET;
      default: return CH_RBRACKET;
    endcase
  endfunction

  // mostly well formed s-expression text with random content, plus some noise
  task automatic build_random_text();
    int n;
    logic [7:0] c;
    while (source_text.size() < RANDOM_ITEMS + 24) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n = $urandom_range(1, 6);
          repeat (n) add_text_byte(atom_char());
        end
        3: add_text_byte(blank_char());
        4, 5: add_text_byte(bracket_char());
        6, 7: begin
          add_text_byte(CH_QUOTE);
          n = $urandom_range(0, 6);
          repeat (n) add_text_byte($urandom_range(0, 3) == 0 ? CH_BACKSLASH : 8'($urandom));
          add_text_byte(CH_QUOTE);
        end
        8: begin
          add_text_byte(CH_SEMICOLON);
          n = $urandom_range(0, 5);
          repeat (n) begin
            do c = 8'($urandom); while (c == CH_NEWLINE);
            add_text_byte(c);
          end
          add_text_byte(CH_NEWLINE);
        end
        default: add_text_byte(8'($urandom));
      endcase
    end
  endtask

  // receiver: one long hold-off early on, then stretches of varying stall density
  initial begin
    int style;
    int stretch;
    wait (!rst);
    repeat ($urandom_range(40, 120)) begin
      @(negedge clk);
      dst_ready <= ($urandom_range(0, 3) != 0);
    end
    @(negedge clk);
    dst_ready <= 1'b0;
    repeat (HOLD_OFF) @(negedge clk);
    forever begin
      style   = $urandom_range(0, 3);
      stretch = $urandom_range(20, 200);
      repeat (stretch) begin
        @(negedge clk);
        case (style)
          0: dst_ready <= 1'b1;
          1: dst_ready <= ($urandom_range(0, 1) == 1);
          2: dst_ready <= ($urandom_range(0, 7) != 0);
          default: dst_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [7:0] opening [24];
    int burst_left;
    int gap;
    burst_left = 0;

    // atoms at the byte extremes, every whitespace but newline and every bracket,
    // escaped and double backslash quotes, open atom and comment at end of text
    opening = '{8'h00, 8'hFF, CH_LPAREN, "a", CH_TAB, CH_VTAB, CH_RPAREN, CH_FORMFEED,
                CH_LBRACKET, CH_RETURN, CH_RBRACKET, CH_SPACE,
                CH_QUOTE, CH_BACKSLASH, CH_QUOTE, CH_QUOTE,
                CH_QUOTE, CH_BACKSLASH, CH_BACKSLASH, CH_QUOTE, "q",
                "k", CH_SEMICOLON, "c"};
    foreach (opening[i]) add_byte(opening[i], i == 20 || i == 23);
    build_random_text();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender: bursts of back-to-back items with random gaps between them
    foreach (source_text[i]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          src_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      src_valid <= 1'b1;
      src_item  <= source_text[i];
      @(posedge clk);
      while (!src_ready) @(posedge clk);
      @(negedge clk);
      burst_left--;
    end
    src_valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/sct_pkg.sv
rtl/sct_decode.sv
rtl/sct_result_queue.sv
rtl/sexpr_char_tokenizer_core.sv
test/sct_checker.sv
test/tb_top.sv
